// ===== hw/rtl/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Shared widths, reset values, register indexes, state, command and status
// types of the Mandelbrot escape-time unit.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 28;

    localparam int ORIGIN_W = 32;
    localparam int STEP_W   = 29;
    localparam int ITER_W   = 14;
    localparam int HUE_W    = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam logic [ORIGIN_W-1:0] ORIGIN_REAL_RST = 32'hDE66_6666;
    localparam logic [ORIGIN_W-1:0] ORIGIN_IMAG_RST = 32'hECCC_CCCD;
    localparam logic [STEP_W-1:0]   STEP_RST        = 29'd2684355;
    localparam logic [ITER_W-1:0]   LIMIT_RST       = 14'd50;

    typedef enum logic [1:0] {
        REG_ORIGIN_REAL = 2'd0,
        REG_ORIGIN_IMAG = 2'd1,
        REG_PIXEL_STEP  = 2'd2,
        REG_ITER_LIMIT  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_TEST,
        ST_UPDATE,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic init;
        logic mul;
        logic update;
        logic set_inside;
        logic div_init;
        logic div_step;
        logic write_out;
    } t_dp_cmd;

    typedef struct packed {
        logic at_limit;
        logic z_big;
        logic escaped;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/met_regs.sv =====
// ----------------------------------------------------------------------------
// met_regs
// APB-style register file: view origin, pixel step and iteration limit.
// ----------------------------------------------------------------------------
module met_regs
    import met_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [DATA_W-1:0]   i_pwdata,
    output logic [DATA_W-1:0]   o_prdata,
    output logic [ORIGIN_W-1:0] o_origin_real,
    output logic [ORIGIN_W-1:0] o_origin_imag,
    output logic [STEP_W-1:0]   o_pixel_step,
    output logic [ITER_W-1:0]   o_iteration_limit
);

    logic [ORIGIN_W-1:0] r_origin_real;
    logic [ORIGIN_W-1:0] r_origin_imag;
    logic [STEP_W-1:0]   r_pixel_step;
    logic [ITER_W-1:0]   r_iteration_limit;
    t_reg_idx            w_idx;
    logic                w_wr;

    assign w_idx = t_reg_idx'(i_paddr[ADDR_W-1:2]);
    assign w_wr  = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_real     <= ORIGIN_REAL_RST;
            r_origin_imag     <= ORIGIN_IMAG_RST;
            r_pixel_step      <= STEP_RST;
            r_iteration_limit <= LIMIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_ORIGIN_REAL: r_origin_real     <= i_pwdata[ORIGIN_W-1:0];
                REG_ORIGIN_IMAG: r_origin_imag     <= i_pwdata[ORIGIN_W-1:0];
                REG_PIXEL_STEP:  r_pixel_step      <= i_pwdata[STEP_W-1:0];
                REG_ITER_LIMIT:  r_iteration_limit <= i_pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ORIGIN_REAL: o_prdata = r_origin_real;
            REG_ORIGIN_IMAG: o_prdata = r_origin_imag;
            REG_PIXEL_STEP:  o_prdata = {{(DATA_W-STEP_W){1'b0}}, r_pixel_step};
            REG_ITER_LIMIT:  o_prdata = {{(DATA_W-ITER_W){1'b0}}, r_iteration_limit};
            default:         o_prdata = '0;
        endcase
    end

    assign o_origin_real     = r_origin_real;
    assign o_origin_imag     = r_origin_imag;
    assign o_pixel_step      = r_pixel_step;
    assign o_iteration_limit = r_iteration_limit;

endmodule

// ===== hw/rtl/met_ctrl.sv =====
// ----------------------------------------------------------------------------
// met_ctrl
// Sequencer: point mapping, iteration loop, hue division and result write.
// ----------------------------------------------------------------------------
module met_ctrl
    import met_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_INIT;
            end
            ST_INIT: begin
                n_state = ST_TEST;
            end
            ST_TEST: begin
                if (i_sts.at_limit)   n_state = ST_WRITE;
                else if (i_sts.z_big) n_state = ST_DIV;
                else                  n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = i_sts.escaped ? ST_DIV : ST_TEST;
            end
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
            end
            ST_TEST: begin
                if (i_sts.at_limit)   o_cmd.set_inside = 1'b1;
                else if (i_sts.z_big) o_cmd.div_init   = 1'b1;
                else                  o_cmd.mul        = 1'b1;
            end
            ST_UPDATE: begin
                if (i_sts.escaped) o_cmd.div_init = 1'b1;
                else               o_cmd.update   = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_WRITE: begin
                o_cmd.write_out = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/met_dp.sv =====
// ----------------------------------------------------------------------------
// met_dp
// Datapath: c mapping, z = z*z + c in fixed point, escape tests, bit-serial
// hue divider and the result register.
// ----------------------------------------------------------------------------
module met_dp
    import met_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [COORD_BITS-1:0] i_column,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [ORIGIN_W-1:0]   i_origin_real,
    input  logic [ORIGIN_W-1:0]   i_origin_imag,
    input  logic [STEP_W-1:0]     i_pixel_step,
    input  logic [ITER_W-1:0]     i_iteration_limit,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic [ITER_W-1:0]     o_iterations,
    output logic                  o_inside_res,
    output logic [HUE_W-1:0]      o_hue
);

    localparam int PRD_W = COORD_BITS + STEP_W;
    localparam int CW    = ((PRD_W + 1 > ORIGIN_W) ? PRD_W + 1 : ORIGIN_W) + 1;
    localparam int ZW    = ((CW > FRAC_BITS + 4) ? CW : FRAC_BITS + 4) + 1;
    localparam int MW    = FRAC_BITS + 1;
    localparam int PW    = 2 * MW;
    localparam int SQ_W  = PW - FRAC_BITS;
    localparam int XW    = SQ_W + 1;
    localparam int NUM_W = ITER_W + HUE_W;
    localparam int DEN_W = ITER_W + HUE_W - 1;
    localparam int CNT_W = $clog2(HUE_W);
    localparam logic signed [ZW-1:0] TWO     = ZW'(1) <<< (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] NEG_TWO = -TWO;

    logic [PRD_W-1:0]        r_prod_r;
    logic [PRD_W-1:0]        r_prod_i;
    logic signed [CW-1:0]    r_cr;
    logic signed [CW-1:0]    r_ci;
    logic signed [ZW-1:0]    r_zr;
    logic signed [ZW-1:0]    r_zi;
    logic [PW-1:0]           r_p_rr;
    logic [PW-1:0]           r_p_ii;
    logic [PW-1:0]           r_p_ri;
    logic                    r_neg;
    logic [ITER_W-1:0]       r_iter;
    logic                    r_inside;
    logic [NUM_W-1:0]        r_rem;
    logic [DEN_W-1:0]        r_den;
    logic [HUE_W-1:0]        r_quot;
    logic [CNT_W-1:0]        r_dcnt;
    logic                    r_o_valid;
    logic [ITER_W-1:0]       r_o_iter;
    logic                    r_o_inside;
    logic [HUE_W-1:0]        r_o_hue;

    logic signed [ZW-1:0]    w_abs_r;
    logic signed [ZW-1:0]    w_abs_i;
    logic [MW-1:0]           w_mag_r;
    logic [MW-1:0]           w_mag_i;
    logic [SQ_W-1:0]         w_sr;
    logic [SQ_W-1:0]         w_si;
    logic [SQ_W:0]           w_sum;
    logic [XW-1:0]           w_cmag;
    logic signed [ZW-1:0]    w_cross;
    logic signed [ZW-1:0]    w_zr_n;
    logic signed [ZW-1:0]    w_zi_n;
    logic signed [CW-1:0]    w_cr_init;
    logic signed [CW-1:0]    w_ci_init;
    logic [NUM_W-1:0]        w_num;
    logic                    w_ge;
    logic                    w_out_free;

    assign w_abs_r = r_zr[ZW-1] ? -r_zr : r_zr;
    assign w_abs_i = r_zi[ZW-1] ? -r_zi : r_zi;
    assign w_mag_r = w_abs_r[MW-1:0];
    assign w_mag_i = w_abs_i[MW-1:0];

    assign w_sr   = r_p_rr[PW-1:FRAC_BITS];
    assign w_si   = r_p_ii[PW-1:FRAC_BITS];
    assign w_sum  = {1'b0, w_sr} + {1'b0, w_si};
    assign w_cmag = r_p_ri[PW-1:FRAC_BITS-1] + XW'(r_neg & (|r_p_ri[FRAC_BITS-2:0]));
    assign w_cross = r_neg ? -$signed({{(ZW-XW){1'b0}}, w_cmag})
                           :  $signed({{(ZW-XW){1'b0}}, w_cmag});
    assign w_zr_n = $signed({{(ZW-SQ_W){1'b0}}, w_sr}) - $signed({{(ZW-SQ_W){1'b0}}, w_si})
                  + $signed({{(ZW-CW){r_cr[CW-1]}}, r_cr});
    assign w_zi_n = w_cross + $signed({{(ZW-CW){r_ci[CW-1]}}, r_ci});

    assign w_cr_init = $signed({{(CW-ORIGIN_W){i_origin_real[ORIGIN_W-1]}}, i_origin_real})
                     + $signed({{(CW-PRD_W){1'b0}}, r_prod_r});
    assign w_ci_init = $signed({{(CW-ORIGIN_W){i_origin_imag[ORIGIN_W-1]}}, i_origin_imag})
                     + $signed({{(CW-PRD_W){1'b0}}, r_prod_i});

    assign w_num      = {r_iter, {HUE_W{1'b0}}} - {{HUE_W{1'b0}}, r_iter};
    assign w_ge       = r_rem >= {1'b0, r_den};
    assign w_out_free = !r_o_valid || i_ready;

    assign o_sts.at_limit = r_iter >= i_iteration_limit;
    assign o_sts.z_big    = (r_zr >= TWO) || (r_zr <= NEG_TWO)
                         || (r_zi >= TWO) || (r_zi <= NEG_TWO);
    assign o_sts.escaped  = w_sum[SQ_W];
    assign o_sts.div_last = r_dcnt == CNT_W'(HUE_W - 1);
    assign o_sts.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod_r <= i_column * i_pixel_step;
            r_prod_i <= i_row * i_pixel_step;
        end
        if (i_cmd.init) begin
            r_cr     <= w_cr_init;
            r_ci     <= w_ci_init;
            r_zr     <= '0;
            r_zi     <= '0;
            r_iter   <= '0;
            r_inside <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_p_rr <= w_mag_r * w_mag_r;
            r_p_ii <= w_mag_i * w_mag_i;
            r_p_ri <= w_mag_r * w_mag_i;
            r_neg  <= r_zr[ZW-1] ^ r_zi[ZW-1];
        end
        if (i_cmd.update) begin
            r_zr   <= w_zr_n;
            r_zi   <= w_zi_n;
            r_iter <= r_iter + 1'b1;
        end
        if (i_cmd.set_inside) begin
            r_inside <= 1'b1;
        end
        if (i_cmd.div_init) begin
            r_rem  <= w_num;
            r_den  <= {i_iteration_limit, {(HUE_W-1){1'b0}}};
            r_quot <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_ge) r_rem <= r_rem - {1'b0, r_den};
            r_den  <= r_den >> 1;
            r_quot <= {r_quot[HUE_W-2:0], w_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.write_out) begin
            r_o_iter   <= r_iter;
            r_o_inside <= r_inside;
            r_o_hue    <= r_inside ? '0 : r_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.write_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_iterations = r_o_iter;
    assign o_inside_res = r_o_inside;
    assign o_hue        = r_o_hue;

endmodule

// ===== hw/rtl/mandelbrot_escape_time_unit.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time count, inside flag and hue byte for one pixel of the view.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes a column and row index; the point
// c = origin + index * pixel_step is formed in signed fixed point with
// FRAC_BITS fraction bits. Output channel (o_valid/i_ready) returns the
// iteration count, the inside flag and the hue 255*count/limit.
// One pixel is worked on at a time. A pixel stops when the squares reach
// four or when z has already left the box of half-width two. Each
// iteration runs the three multipliers (two squares and the cross product),
// then the escape test and the update of z; c mapping comes before the
// loop and an eight-step bit-serial hue divider after it.
// A pixel that reaches the limit skips the divider.
// The result sits in an output register, so o_ready rises again while a
// result waits; a further pixel then holds in its final state until the
// receiver takes the waiting beat.
// Registers (APB, byte address 4*i): origin_real, origin_imag, pixel_step,
// iteration_limit. Write them only while the unit is idle.
// Reset is synchronous: it empties the output register, returns the
// sequencer to idle and loads the default view.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit
    import met_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_column,
    input  logic [COORD_BITS-1:0] i_row,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ITER_W-1:0]     o_iterations,
    output logic                  o_inside_res,
    output logic [HUE_W-1:0]      o_hue
);

    logic [ORIGIN_W-1:0] w_origin_real;
    logic [ORIGIN_W-1:0] w_origin_imag;
    logic [STEP_W-1:0]   w_pixel_step;
    logic [ITER_W-1:0]   w_iteration_limit;
    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;

    assign pready = 1'b1;

    met_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_prdata          (prdata),
        .o_origin_real     (w_origin_real),
        .o_origin_imag     (w_origin_imag),
        .o_pixel_step      (w_pixel_step),
        .o_iteration_limit (w_iteration_limit)
    );

    met_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    met_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_origin_real     (w_origin_real),
        .i_origin_imag     (w_origin_imag),
        .i_pixel_step      (w_pixel_step),
        .i_iteration_limit (w_iteration_limit),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_iterations      (o_iterations),
        .o_inside_res      (o_inside_res),
        .o_hue             (o_hue)
    );

`ifndef SYNTH
    a_one_pixel_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second pixel taken while one is in flight");

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.write_out))
        else $error("result valid without a result write");

    a_inside_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_res) |-> (o_hue == '0 && o_iterations == w_iteration_limit))
        else $error("inside result with wrong count or hue");

    a_escaped_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_res) |-> (o_iterations < w_iteration_limit))
        else $error("escaped result at or beyond the limit");
`endif

endmodule

// ===== tb/sv/mandelbrot_escape_time_check.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_check
// Watches the register port and both pixel channels, predicts the escape
// count, inside flag and hue of every accepted pixel, and compares each
// result beat against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_check
    import met_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic                      i_pready,
    input  logic [ADDR_W-1:0]         i_paddr,
    input  logic [DATA_W-1:0]         i_pwdata,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [COORD_BITS_DEF-1:0] i_column,
    input  logic [COORD_BITS_DEF-1:0] i_row,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [ITER_W-1:0]         i_iterations,
    input  logic                      i_inside_res,
    input  logic [HUE_W-1:0]          i_hue,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = FRAC_BITS_DEF;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic              inside_res;
        logic [HUE_W-1:0]  hue;
    } t_pixel_result;

    logic [ORIGIN_W-1:0] view_re;
    logic [ORIGIN_W-1:0] view_im;
    logic [STEP_W-1:0]   view_step;
    logic [ITER_W-1:0]   view_limit;
    t_pixel_result       pixel_q[$];
    int                  fails;

    function automatic t_pixel_result trace_orbit(input logic [COORD_BITS_DEF-1:0] col,
                                                  input logic [COORD_BITS_DEF-1:0] row);
        longint        cr;
        longint        ci;
        longint        zr;
        longint        zi;
        longint        sq_re;
        longint        sq_im;
        longint        twice_re_im;
        longint        bound;
        longint        radius_sq;
        int unsigned   n;
        t_pixel_result res;
        cr        = longint'($signed(view_re)) + longint'(col) * longint'(view_step);
        ci        = longint'($signed(view_im)) + longint'(row) * longint'(view_step);
        bound     = 64'sd2 <<< FRAC;
        radius_sq = 64'sd4 <<< FRAC;
        zr        = 0;
        zi        = 0;
        n         = 0;
        while (n < view_limit) begin
            if (zr >= bound || zr <= -bound || zi >= bound || zi <= -bound) break;
            sq_re = (zr * zr) >>> FRAC;
            sq_im = (zi * zi) >>> FRAC;
            if (sq_re + sq_im >= radius_sq) break;
            twice_re_im = (zr * zi) >>> (FRAC - 1);
            zr    = sq_re - sq_im + cr;
            zi    = twice_re_im + ci;
            n++;
        end
        res.iterations = ITER_W'(n);
        if (n >= view_limit) begin
            res.inside_res = 1'b1;
            res.hue        = '0;
        end else begin
            res.inside_res = 1'b0;
            res.hue        = HUE_W'((255 * n) / view_limit);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result got;
        t_pixel_result want;
        if (!i_rst_n) begin
            view_re    <= ORIGIN_REAL_RST;
            view_im    <= ORIGIN_IMAG_RST;
            view_step  <= STEP_RST;
            view_limit <= LIMIT_RST;
            pixel_q.delete();
            fails = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_ORIGIN_REAL: view_re    <= i_pwdata;
                    REG_ORIGIN_IMAG: view_im    <= i_pwdata;
                    REG_PIXEL_STEP:  view_step  <= i_pwdata[STEP_W-1:0];
                    REG_ITER_LIMIT:  view_limit <= i_pwdata[ITER_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_iterations, i_inside_res, i_hue};
                if (pixel_q.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result beat: iterations %0d inside %0b hue %0d",
                                 got.iterations, got.inside_res, got.hue);
                    fails++;
                end else begin
                    want = pixel_q.pop_front();
                    if (got.iterations !== want.iterations ||
                        got.inside_res !== want.inside_res || got.hue !== want.hue) begin
                        if (fails < 10)
                            $display("result mismatch (expected/actual): iterations %0d/%0d %s",
                                     want.iterations, got.iterations,
                                     $sformatf("inside %0b/%0b hue %0d/%0d",
                                               want.inside_res, got.inside_res,
                                               want.hue, got.hue));
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                pixel_q.push_back(trace_orbit(i_column, i_row));
            o_pending    <= pixel_q.size();
            o_fail_count <= fails;
        end
    end

endmodule

// ===== tb/sv/mandelbrot_escape_time_unit_test.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit_test
// Drives pixels through the escape-time unit over a series of views and
// limits, from the reset view to extreme origins, steps and limits, with
// random gaps and stalls on both channels; the checker judges every result.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit_test
    import met_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB          = COORD_BITS_DEF;
    localparam int IDLE_PCT    = 23;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 600;
    localparam int NUM_VIEWS   = 9;
    localparam int CALM_VIEW   = 6;

    localparam logic [CB-1:0] PROBE_COL [12] = '{12'd0, 12'd4095, 12'd0, 12'd4095,
                                                 12'hAAA, 12'h555, 12'd150, 12'd210,
                                                 12'd300, 12'd80, 12'd0, 12'd10};
    localparam logic [CB-1:0] PROBE_ROW [12] = '{12'd0, 12'd4095, 12'd4095, 12'd0,
                                                 12'h555, 12'hAAA, 12'd120, 12'd120,
                                                 12'd120, 12'd120, 12'd120, 12'd120};

    typedef struct packed {
        logic [ORIGIN_W-1:0] re;
        logic [ORIGIN_W-1:0] im;
        logic [STEP_W-1:0]   step;
        logic [ITER_W-1:0]   limit;
        logic [15:0]         pixels;
        logic [CB-1:0]       col_span;
        logic [CB-1:0]       row_span;
    } t_view;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid;
    logic              o_ready;
    logic [CB-1:0]     i_column;
    logic [CB-1:0]     i_row;
    logic              o_valid;
    logic              i_ready;
    logic [ITER_W-1:0] o_iterations;
    logic              o_inside_res;
    logic [HUE_W-1:0]  o_hue;
    logic              calm;
    int                mismatches;
    int                pixels_in_flight;

    mandelbrot_escape_time_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_column    (i_column),
        .i_row       (i_row),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_iterations(o_iterations),
        .o_inside_res(o_inside_res),
        .o_hue       (o_hue)
    );

    mandelbrot_escape_time_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_iterations(o_iterations),
        .i_inside_res(o_inside_res),
        .i_hue       (o_hue),
        .o_fail_count(mismatches),
        .o_pending   (pixels_in_flight)
    );

    function automatic t_view view_of(input int idx);
        case (idx)
            1:       return '{32'h8000_0000, 32'h7FFF_FFFF, 29'h1000_0000, 14'd2,
                              16'd80, 12'd4095, 12'd4095};
            2:       return '{32'h0000_0000, 32'h0000_0000, 29'd1, 14'h3FFF,
                              16'd2, 12'd15, 12'd15};
            3:       return '{32'h7FFF_FFFF, 32'h8000_0000, 29'd1, 14'd0,
                              16'd40, 12'd4095, 12'd4095};
            4:       return '{32'hF400_0000, 32'h0199_999A, 29'd16384, 14'd200,
                              16'd250, 12'd255, 12'd255};
            5:       return '{ORIGIN_REAL_RST, ORIGIN_IMAG_RST, STEP_RST, 14'd10000,
                              16'd4, 12'd300, 12'd240};
            6:       return '{32'hE000_0000, 32'hE800_0000, 29'h000C_0000, 14'd100,
                              16'd400, 12'd1023, 12'd1023};
            7:       return '{32'hE000_0000, 32'hEC00_0000, 29'h0028_0000, 14'd1,
                              16'd60, 12'd255, 12'd255};
            8:       return '{32'hE000_0000, 32'hEC00_0000, 29'h0028_0000, 14'd25,
                              16'd300, 12'd255, 12'd255};
            default: return '{ORIGIN_REAL_RST, ORIGIN_IMAG_RST, STEP_RST, LIMIT_RST,
                              16'd500, 12'd300, 12'd240};
        endcase
    endfunction

    function automatic logic [CB-1:0] pick_coord(input logic [CB-1:0] span);
        if ($urandom_range(99) < 85)
            return CB'($urandom_range(span));
        return CB'($urandom_range(4095));
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(input logic [CB-1:0] col, input logic [CB-1:0] row);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid  <= 1'b1;
        i_column <= col;
        i_row    <= row;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_pixels();
        do @(posedge i_clk); while (pixels_in_flight != 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, one long hold-off after HOLD_AT results
    initial begin
        int  taken;
        bit  held;
        taken = 0;
        held  = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                taken++;
            if (taken == HOLD_AT && !held) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        t_view view;
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        i_valid  <= 1'b0;
        i_column <= '0;
        i_row    <= '0;
        calm     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int v = 0; v < NUM_VIEWS; v++) begin
            view = view_of(v);
            if (v > 0) begin
                drain_pixels();
                write_reg(REG_ORIGIN_REAL, view.re);
                write_reg(REG_ORIGIN_IMAG, view.im);
                write_reg(REG_PIXEL_STEP, DATA_W'(view.step));
                write_reg(REG_ITER_LIMIT, DATA_W'(view.limit));
            end
            calm <= (v == CALM_VIEW);
            if (v == 0) begin
                for (int k = 0; k < 12; k++)
                    send_pixel(PROBE_COL[k], PROBE_ROW[k]);
            end
            for (int k = 0; k < int'(view.pixels); k++)
                send_pixel(pick_coord(view.col_span), pick_coord(view.row_span));
            i_valid <= 1'b0;
        end

        drain_pixels();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pixels_in_flight == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
